[sv/kcvg_pkg.sv]
// Shared types and constants for the Koch curve vertex generator.
// No dependencies; every other file imports this package.
`default_nettype none

package kcvg_pkg;

  // Field widths
  localparam int IN_W    = 32;  // Q16.16 coordinate fields
  localparam int IDX_W   = 16;  // vertex index field
  localparam int DEPTH_W = 4;   // curve_depth register

  // Internal datapath widths (Q16.16 with integer headroom)
  localparam int VEC_W   = 33;  // segment vector, exact end - start
  localparam int THIRD_W = 32;  // v/3, always below 2^31 in magnitude
  localparam int POS_W   = 35;  // running start point
  localparam int SUM_W   = 36;  // start + vector before saturation
  localparam int PROD_W  = 50;  // rotation product sums
  localparam int FRAC_W  = 16;

  // Divide by three: n = hi*2^16 + lo, n/3 = hi*21845 + (hi + lo)/3
  localparam int DIV_LO_W    = 16;
  localparam int DIV_HI_W    = VEC_W - DIV_LO_W;
  localparam int DIV_MID_W   = DIV_HI_W + 1;
  localparam int DIV_RECIP_W = 19;
  localparam int DIV_P2_W    = DIV_MID_W + DIV_RECIP_W;
  localparam int DIV3_SHIFT  = 20;
  localparam int DIV_Q2_W    = DIV_P2_W - DIV3_SHIFT;
  localparam logic [14:0]            DIV3_HI_MUL = 15'd21845;
  localparam logic [DIV_RECIP_W-1:0] DIV3_RECIP  = 19'd349526;

  // Rotation by 60 degrees, Q0.16 constants
  localparam logic [16:0] SIN60_Q16   = 17'd56756;
  localparam int          COS60_SHIFT = 15;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam logic [ADDR_W-3:0]  REG_CURVE_DEPTH = 1'b0;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET     = 4'd5;

  // Base-4 digit of the index at one level
  typedef enum logic [1:0] {
    DIG_KEEP     = 2'd0,
    DIG_TURN_POS = 2'd1,
    DIG_TURN_NEG = 2'd2,
    DIG_ADVANCE  = 2'd3
  } kcvg_digit_t;

  typedef struct packed {
    logic        active;
    kcvg_digit_t digit;
  } kcvg_ctl_t;

  typedef struct packed {
    logic                    oor;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
  } kcvg_item_t;

endpackage

`default_nettype wire

[sv/kcvg_div3.sv]
// Three-stage signed divide by three, rounded to nearest.
// Uses kcvg_pkg widths and reciprocal constants.
`default_nettype none

module kcvg_div3 (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [kcvg_pkg::VEC_W-1:0]    x,
  output logic signed [kcvg_pkg::THIRD_W-1:0]  q
);
  import kcvg_pkg::*;

  localparam logic signed [VEC_W:0] ONE_W = 1;

  logic signed [VEC_W:0]   x_ext;
  logic signed [VEC_W:0]   n_wide;
  logic [VEC_W-1:0]        n;
  logic [DIV_HI_W-1:0]     hi_next;
  logic [DIV_MID_W-1:0]    mid_next;
  logic [DIV_HI_W-1:0]     hi;
  logic [DIV_MID_W-1:0]    mid;
  logic                    neg;
  logic [THIRD_W-1:0]      p1_next;
  logic [DIV_P2_W-1:0]     p2_full;
  logic [THIRD_W-1:0]      p1;
  logic [DIV_Q2_W-1:0]     q2;
  logic                    neg2;
  logic [THIRD_W-1:0]      mag;
  logic signed [THIRD_W-1:0] q_next;

  // Stage 1: n = |x| + 1, split into high and low halves
  always_comb begin
    x_ext    = {x[VEC_W-1], x};
    n_wide   = x[VEC_W-1] ? (ONE_W - x_ext) : (x_ext + ONE_W);
    n        = n_wide[VEC_W-1:0];
    hi_next  = n[VEC_W-1:DIV_LO_W];
    mid_next = DIV_MID_W'(hi_next) + DIV_MID_W'(n[DIV_LO_W-1:0]);
  end

  // Stage 2: partial products
  always_comb begin
    p1_next = THIRD_W'(hi) * THIRD_W'(DIV3_HI_MUL);
    p2_full = DIV_P2_W'(mid) * DIV_P2_W'(DIV3_RECIP);
  end

  // Stage 3: combine and restore the sign
  always_comb begin
    mag    = p1 + THIRD_W'(q2);
    q_next = neg2 ? -signed'(mag) : signed'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi   <= hi_next;
      mid  <= mid_next;
      neg  <= x[VEC_W-1];
      p1   <= p1_next;
      q2   <= p2_full[DIV_P2_W-1:DIV3_SHIFT];
      neg2 <= neg;
      q    <= q_next;
    end
  end

endmodule

`default_nettype wire

[sv/kcvg_level.sv]
// One subdivision level: six pipeline stages (divide by three, rotation
// products, rounding, digit select). Uses kcvg_pkg and kcvg_div3.
`default_nettype none

module kcvg_level #(
  parameter int MAX_LEVELS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  kcvg_pkg::kcvg_item_t                    in_item,
  input  kcvg_pkg::kcvg_ctl_t [MAX_LEVELS-1:0]    in_ctl,
  output logic                                    out_valid,
  output kcvg_pkg::kcvg_item_t                    out_item,
  output kcvg_pkg::kcvg_ctl_t [MAX_LEVELS-1:0]    out_ctl
);
  import kcvg_pkg::*;

  localparam int STAGES = 6;
  localparam int SIDE   = STAGES - 1;
  localparam logic signed [PROD_W-1:0] SIN60_W    = PROD_W'(SIN60_Q16);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  function automatic logic signed [VEC_W-1:0] q16_round(
    input logic signed [PROD_W-1:0] raw
  );
    logic signed [PROD_W-1:0] r;
    r = raw + ROUND_HALF;
    return signed'(r[FRAC_W +: VEC_W]);
  endfunction

  logic [STAGES-1:0]                 vld;
  kcvg_item_t                        item_d [SIDE];
  kcvg_ctl_t [MAX_LEVELS-1:0]        ctl_d  [SIDE];

  logic signed [THIRD_W-1:0]         tx3, ty3;
  logic signed [THIRD_W-1:0]         tx4, ty4;
  logic signed [PROD_W-1:0]          sx_prod, sy_prod;
  logic signed [PROD_W-1:0]          ctx, cty;
  logic signed [THIRD_W-1:0]         tx5, ty5;
  logic signed [VEC_W-1:0]           px, py, mx, my;

  kcvg_item_t                        cur;
  kcvg_ctl_t                         lvl;
  kcvg_item_t                        upd;
  logic signed [POS_W-1:0]           off_x, off_y;

  kcvg_div3 u_div_x (.clk(clk), .en(en), .x(in_item.vx), .q(tx3));
  kcvg_div3 u_div_y (.clk(clk), .en(en), .x(in_item.vy), .q(ty3));

  // Stage 4: sine products (the cosine term is a shift)
  always_ff @(posedge clk) begin
    if (en) begin
      tx4     <= tx3;
      ty4     <= ty3;
      sx_prod <= PROD_W'(tx3) * SIN60_W;
      sy_prod <= PROD_W'(ty3) * SIN60_W;
    end
  end

  // Stage 5: rotate both ways and round
  always_comb begin
    ctx = PROD_W'(tx4) <<< COS60_SHIFT;
    cty = PROD_W'(ty4) <<< COS60_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx5 <= tx4;
      ty5 <= ty4;
      px  <= q16_round(ctx - sy_prod);
      py  <= q16_round(sx_prod + cty);
      mx  <= q16_round(ctx + sy_prod);
      my  <= q16_round(cty - sx_prod);
    end
  end

  // Stage 6: pick the sub-segment for this digit
  always_comb begin
    cur   = item_d[SIDE-1];
    lvl   = ctl_d[SIDE-1][MAX_LEVELS-1];
    upd   = cur;
    off_x = '0;
    off_y = '0;
    unique case (lvl.digit)
      DIG_KEEP: begin
        upd.vx = VEC_W'(tx5);
        upd.vy = VEC_W'(ty5);
      end
      DIG_TURN_POS: begin
        off_x  = POS_W'(tx5);
        off_y  = POS_W'(ty5);
        upd.vx = px;
        upd.vy = py;
      end
      DIG_TURN_NEG: begin
        off_x  = POS_W'(tx5) + POS_W'(px);
        off_y  = POS_W'(ty5) + POS_W'(py);
        upd.vx = mx;
        upd.vy = my;
      end
      DIG_ADVANCE: begin
        off_x  = POS_W'(tx5) <<< 1;
        off_y  = POS_W'(ty5) <<< 1;
        upd.vx = VEC_W'(tx5);
        upd.vy = VEC_W'(ty5);
      end
    endcase
    upd.sx = cur.sx + off_x;
    upd.sy = cur.sy + off_y;
    // levels below the configured depth pass the item through
    if (!lvl.active) begin
      upd = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_d[0] <= in_item;
      ctl_d[0]  <= in_ctl;
      for (int k = 1; k < SIDE; k++) begin
        item_d[k] <= item_d[k-1];
        ctl_d[k]  <= ctl_d[k-1];
      end
      out_item <= upd;
      // next level finds its control at the top entry
      out_ctl  <= ctl_d[SIDE-1] << $bits(kcvg_ctl_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

`default_nettype wire

[sv/kcvg_out.sv]
// Final sum, saturation and output register with a one-entry skid buffer.
// Uses kcvg_pkg; drives the pipeline advance enable.
`default_nettype none

module kcvg_out #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  kcvg_pkg::kcvg_item_t                in_item,
  output logic                                en,
  output logic                                valid,
  input  logic                                stall,
  output logic signed [kcvg_pkg::IN_W-1:0]    vertex_x,
  output logic signed [kcvg_pkg::IN_W-1:0]    vertex_y,
  output logic                                index_out_of_range
);
  import kcvg_pkg::*;

  localparam int CMP_W = ((COORD_BITS > SUM_W) ? COORD_BITS : SUM_W) + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI = (CMP_W'(1) <<< (COORD_BITS - 1)) - CMP_W'(1);
  localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI - CMP_W'(1);

  function automatic logic signed [IN_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w > SAT_HI) begin
      w = SAT_HI;
    end else if (w < SAT_LO) begin
      w = SAT_LO;
    end
    return signed'(w[IN_W-1:0]);
  endfunction

  logic                       vld_a;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic                       oor_a;
  logic signed [IN_W-1:0]     res_x, res_y;
  logic                       skid_full;
  logic signed [IN_W-1:0]     skid_x, skid_y;
  logic                       skid_oor;
  logic                       take_out;

  assign en       = !skid_full;
  assign take_out = !valid || !stall;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x <= SUM_W'(in_item.sx) + SUM_W'(in_item.vx);
      sum_y <= SUM_W'(in_item.sy) + SUM_W'(in_item.vy);
      oor_a <= in_item.oor;
    end
  end

  always_comb begin
    res_x = oor_a ? '0 : sat_coord(sum_x);
    res_y = oor_a ? '0 : sat_coord(sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      valid     <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (en) begin
        vld_a <= in_valid;
      end
      if (take_out) begin
        valid     <= skid_full || vld_a;
        skid_full <= 1'b0;
      end else if (en && vld_a) begin
        // output held: park the request, pipeline stops next cycle
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      if (skid_full) begin
        vertex_x           <= skid_x;
        vertex_y           <= skid_y;
        index_out_of_range <= skid_oor;
      end else begin
        vertex_x           <= res_x;
        vertex_y           <= res_y;
        index_out_of_range <= oor_a;
      end
    end else if (en && vld_a) begin
      skid_x   <= res_x;
      skid_y   <= res_y;
      skid_oor <= oor_a;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> valid)
    else $error("skid buffer full while output register empty");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    valid && index_out_of_range |-> vertex_x == '0 && vertex_y == '0)
    else $error("out-of-range request with nonzero coordinates");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(valid && stall))
    else $error("skid buffer filled while output was free");

endmodule

`default_nettype wire

[sv/koch_curve_vertex_generator_top.sv]
// Koch curve vertex generator: one vertex per segment request.
// Input request: start_x/start_y/end_x/end_y (Q16.16) and vertex_index on
//   seg_valid/seg_stall; a request is taken when seg_valid is high and
//   seg_stall is low at a rising edge.
// Result: vertex_x/vertex_y (Q16.16) and index_out_of_range on
//   vertex_valid/vertex_stall, one result per request, in request order.
// curve_depth is written over the APB port at byte address 0 (reset 5);
//   write it only while no request is in flight.
// Throughput: one request per cycle while seg_stall is low. Each of the
//   MAX_LEVELS levels is a six-stage pipeline section (divide by three,
//   rotation multiply, rounding, digit select); an entry register comes
//   before the levels and a sum register and the output register follow
//   them. Every request passes all levels for any configured depth.
// Reset clears all valid bits and the skid buffer and restores curve_depth.
// When the receiver stalls, the output register holds its result and one
//   more result is parked in a skid buffer; seg_stall then rises for as
//   long as that buffer is occupied. Nothing is dropped or repeated.
// Depends on kcvg_pkg, kcvg_level, kcvg_div3 and kcvg_out.
`default_nettype none

module koch_curve_vertex_generator_top #(
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // segment requests
  input  logic                                    seg_valid,
  output logic                                    seg_stall,
  input  logic signed [kcvg_pkg::IN_W-1:0]        start_x,
  input  logic signed [kcvg_pkg::IN_W-1:0]        start_y,
  input  logic signed [kcvg_pkg::IN_W-1:0]        end_x,
  input  logic signed [kcvg_pkg::IN_W-1:0]        end_y,
  input  logic [kcvg_pkg::IDX_W-1:0]              vertex_index,
  // vertex results
  output logic                                    vertex_valid,
  input  logic                                    vertex_stall,
  output logic signed [kcvg_pkg::IN_W-1:0]        vertex_x,
  output logic signed [kcvg_pkg::IN_W-1:0]        vertex_y,
  output logic                                    index_out_of_range,
  // configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [kcvg_pkg::ADDR_W-1:0]             paddr,
  input  logic [kcvg_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [kcvg_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);
  import kcvg_pkg::*;

  localparam int DSW = $clog2(MAX_LEVELS + 1);
  localparam int XW  = (2 * MAX_LEVELS > IDX_W) ? 2 * MAX_LEVELS : IDX_W;

  logic [DEPTH_W-1:0]          curve_depth;
  logic [ADDR_W-3:0]           reg_index;
  logic [DSW-1:0]              depth_sat;
  logic [XW-1:0]               idx_ext;
  logic                        en;

  kcvg_item_t                  item_next;
  kcvg_ctl_t [MAX_LEVELS-1:0]  ctl_next;
  logic                        s0_valid;
  kcvg_item_t                  s0_item;
  kcvg_ctl_t [MAX_LEVELS-1:0]  s0_ctl;

  logic [MAX_LEVELS:0]         lvl_valid;
  kcvg_item_t                  lvl_item [MAX_LEVELS+1];
  kcvg_ctl_t [MAX_LEVELS-1:0]  lvl_ctl  [MAX_LEVELS+1];

  // Configuration register
  assign reg_index = paddr[ADDR_W-1:2];
  assign pready    = 1'b1;
  assign prdata    = (reg_index == REG_CURVE_DEPTH) ? APB_DATA_W'(curve_depth) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_depth <= DEPTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_CURVE_DEPTH) begin
      curve_depth <= pwdata[DEPTH_W-1:0];
    end
  end

  // Entry stage: segment vector, per-level digits, range check
  always_comb begin
    depth_sat = (curve_depth > MAX_LEVELS) ? DSW'(MAX_LEVELS) : DSW'(curve_depth);
    idx_ext   = XW'(vertex_index);
    // entry i drives level MAX_LEVELS-1-i; top entries are used first
    for (int i = 0; i < MAX_LEVELS; i++) begin
      ctl_next[i].active = (i < depth_sat);
      ctl_next[i].digit  = kcvg_digit_t'(idx_ext[2*i +: 2]);
    end
    item_next.oor = ((idx_ext >> (2 * depth_sat)) != '0);
    item_next.sx  = POS_W'(start_x);
    item_next.sy  = POS_W'(start_y);
    item_next.vx  = VEC_W'(end_x) - VEC_W'(start_x);
    item_next.vy  = VEC_W'(end_y) - VEC_W'(start_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item <= item_next;
      s0_ctl  <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= seg_valid;
    end
  end

  assign seg_stall    = !en;
  assign lvl_valid[0] = s0_valid;
  assign lvl_item[0]  = s0_item;
  assign lvl_ctl[0]   = s0_ctl;

  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_level
    kcvg_level #(
      .MAX_LEVELS (MAX_LEVELS)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lvl_valid[l]),
      .in_item   (lvl_item[l]),
      .in_ctl    (lvl_ctl[l]),
      .out_valid (lvl_valid[l+1]),
      .out_item  (lvl_item[l+1]),
      .out_ctl   (lvl_ctl[l+1])
    );
  end

  kcvg_out #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (lvl_valid[MAX_LEVELS]),
    .in_item            (lvl_item[MAX_LEVELS]),
    .en                 (en),
    .valid              (vertex_valid),
    .stall              (vertex_stall),
    .vertex_x           (vertex_x),
    .vertex_y           (vertex_y),
    .index_out_of_range (index_out_of_range)
  );

endmodule

`default_nettype wire

[tb/sv/koch_curve_vertex_generator_top_tb.sv]
// Self-checking testbench for koch_curve_vertex_generator_top.
// A behavioral vertex predictor checks every result; depth is set over APB.
// Depends on kcvg_pkg and the generator RTL only.
`default_nettype none

module koch_curve_vertex_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcvg_pkg::*;

  localparam int     MAX_DEPTH   = 8;
  localparam int     LATENCY     = 6 * MAX_DEPTH + 2;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     PHASE_ITEMS = 300;
  localparam longint COS60       = 32768;
  localparam longint SIN60       = 56756;
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;

  localparam logic [ADDR_W-3:0]  REG_UNUSED  = 1'b1;
  localparam logic [ADDR_W-1:0]  ADDR_DEPTH  = {REG_CURVE_DEPTH, 2'b00};
  localparam logic [ADDR_W-1:0]  ADDR_UNUSED = {REG_UNUSED, 2'b00};

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic                   oor;
    logic [IDX_W-1:0]       idx;
  } vertex_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   seg_valid    = 1'b0;
  logic                   seg_stall;
  logic signed [IN_W-1:0] start_x      = '0;
  logic signed [IN_W-1:0] start_y      = '0;
  logic signed [IN_W-1:0] end_x        = '0;
  logic signed [IN_W-1:0] end_y        = '0;
  logic [IDX_W-1:0]       vertex_index = '0;

  logic                   vertex_valid;
  logic                   vertex_stall = 1'b0;
  logic signed [IN_W-1:0] vertex_x;
  logic signed [IN_W-1:0] vertex_y;
  logic                   index_out_of_range;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [ADDR_W-1:0]      paddr   = '0;
  logic [APB_DATA_W-1:0]  pwdata  = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  vertex_exp_t      vertex_q[$];
  logic [DEPTH_W-1:0] depth_model = DEPTH_RESET;
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               send_idle_pct  = 0;
  int               stall_pct      = 0;

  koch_curve_vertex_generator_top dut (
    .clk                (clk),
    .rst                (rst),
    .seg_valid          (seg_valid),
    .seg_stall          (seg_stall),
    .start_x            (start_x),
    .start_y            (start_y),
    .end_x              (end_x),
    .end_y              (end_y),
    .vertex_index       (vertex_index),
    .vertex_valid       (vertex_valid),
    .vertex_stall       (vertex_stall),
    .vertex_x           (vertex_x),
    .vertex_y           (vertex_y),
    .index_out_of_range (index_out_of_range),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    vertex_stall = ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Vertex predictor
  // ---------------------------------------------------------------------------
  function automatic longint third_round(longint v);
    if (v >= 0) return (v + 1) / 3;
    return -((-v + 1) / 3);
  endfunction

  // round(v / 2^16), ties toward plus infinity
  function automatic longint round_q16(longint v);
    longint w;
    w = v + 32768;
    if (w >= 0) return w / 65536;
    return -((-w - 1) / 65536) - 1;
  endfunction

  function automatic logic signed [IN_W-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) return IN_W'(COORD_MAX);
    if (v < COORD_MIN) return IN_W'(COORD_MIN);
    return IN_W'(v);
  endfunction

  function automatic int active_levels();
    return (depth_model > MAX_DEPTH) ? MAX_DEPTH : int'(depth_model);
  endfunction

  function automatic vertex_exp_t predict_vertex(logic signed [IN_W-1:0] sx0,
                                                 logic signed [IN_W-1:0] sy0,
                                                 logic signed [IN_W-1:0] ex0,
                                                 logic signed [IN_W-1:0] ey0,
                                                 logic [IDX_W-1:0] idx);
    vertex_exp_t r;
    longint      pos_x, pos_y, vx, vy, tx, ty, plus_x, plus_y, minus_x, minus_y;
    int          levels;
    kcvg_digit_t dig;
    levels = active_levels();
    r.idx  = idx;
    if (longint'(idx) >= (longint'(1) << (2 * levels))) begin
      r.x   = '0;
      r.y   = '0;
      r.oor = 1'b1;
      return r;
    end
    pos_x = longint'(sx0);
    pos_y = longint'(sy0);
    vx    = longint'(ex0) - pos_x;
    vy    = longint'(ey0) - pos_y;
    for (int l = 0; l < levels; l++) begin
      dig     = kcvg_digit_t'(2'(idx >> (2 * (levels - 1 - l))));
      tx      = third_round(vx);
      ty      = third_round(vy);
      plus_x  = round_q16(tx * COS60 - ty * SIN60);
      plus_y  = round_q16(tx * SIN60 + ty * COS60);
      minus_x = round_q16(tx * COS60 + ty * SIN60);
      minus_y = round_q16(ty * COS60 - tx * SIN60);
      case (dig)
        DIG_KEEP: begin
          vx = tx;
          vy = ty;
        end
        DIG_TURN_POS: begin
          pos_x += tx;
          pos_y += ty;
          vx = plus_x;
          vy = plus_y;
        end
        DIG_TURN_NEG: begin
          pos_x += tx + plus_x;
          pos_y += ty + plus_y;
          vx = minus_x;
          vy = minus_y;
        end
        default: begin
          pos_x += 2 * tx;
          pos_y += 2 * ty;
          vx = tx;
          vy = ty;
        end
      endcase
    end
    r.x   = clamp_coord(pos_x + vx);
    r.y   = clamp_coord(pos_y + vy);
    r.oor = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [IDX_W-1:0] idx,
                                 logic [IN_W-1:0] got, logic [IN_W-1:0] want);
    if (mismatch_count < 40)
      $display("mismatch %s at cycle %0d: index %0d got %h want %h",
               what, cycle_count, idx, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    vertex_exp_t want;
    if (!rst && vertex_valid && !vertex_stall) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected result", '0, vertex_x, '0);
      end else begin
        want = vertex_q.pop_front();
        if (vertex_x !== want.x)
          report_mismatch("vertex_x", want.idx, vertex_x, want.x);
        if (vertex_y !== want.y)
          report_mismatch("vertex_y", want.idx, vertex_y, want.y);
        if (index_out_of_range !== want.oor)
          report_mismatch("index_out_of_range", want.idx,
                          IN_W'(index_out_of_range), IN_W'(want.oor));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_segment(logic signed [IN_W-1:0] sx, logic signed [IN_W-1:0] sy,
                              logic signed [IN_W-1:0] ex, logic signed [IN_W-1:0] ey,
                              logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_valid = 1'b0;
      @(negedge clk);
    end
    seg_valid    = 1'b1;
    start_x      = sx;
    start_y      = sy;
    end_x        = ex;
    end_y        = ey;
    vertex_index = idx;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    vertex_q.push_back(predict_vertex(sx, sy, ex, ey, idx));
  endtask

  // Hold off new requests until every pending vertex has come back.
  task automatic wait_drained();
    @(negedge clk);
    seg_valid = 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[ADDR_W-1:2] == REG_CURVE_DEPTH) depth_model = data[DEPTH_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_depth(logic [DEPTH_W-1:0] d);
    write_register(ADDR_DEPTH, {(APB_DATA_W - DEPTH_W)'($urandom()), d});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [IN_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom();
    if (r < 75) return IN_W'(int'($urandom_range(1 << 21)) - (1 << 20));
    case ($urandom_range(3))
      0:       return IN_W'(COORD_MIN);
      1:       return IN_W'(COORD_MAX);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int r, span, v;
    r    = $urandom_range(99);
    span = 1 << (2 * active_levels());
    if (r < 70) return IDX_W'($urandom_range(span - 1, 0));
    if (r < 85) return IDX_W'($urandom());
    v = span - 1 + $urandom_range(1);
    return (v > 65535) ? 16'hFFFF : IDX_W'(v);
  endfunction

  task automatic send_random_segment(logic [IDX_W-1:0] idx);
    logic signed [IN_W-1:0] sx, sy, ex, ey;
    sx = pick_coord();
    sy = pick_coord();
    if ($urandom_range(1)) begin
      ex = pick_coord();
      ey = pick_coord();
    end else begin
      ex = sx + IN_W'(int'($urandom_range(1 << 24)) - (1 << 23));
      ey = sy + IN_W'(int'($urandom_range(1 << 24)) - (1 << 23));
    end
    send_segment(sx, sy, ex, ey, idx);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset depth of 5: coordinate extremes, uniform digit strings, index range edges.
  task automatic test_directed_extremes();
    logic signed [IN_W-1:0] lo, hi;
    lo = IN_W'(COORD_MIN);
    hi = IN_W'(COORD_MAX);
    send_segment(lo, lo, hi, hi, 16'd0);
    send_segment(hi, hi, lo, lo, 16'd341);
    send_segment(lo, hi, hi, lo, 16'd682);
    send_segment(hi, lo, lo, hi, 16'd1023);
    send_segment('0, '0, '0, '0, 16'd1023);
    send_segment('0, '0, 32'sd3 <<< 16, '0, 16'd341);
    send_segment('0, '0, -32'sd1, -32'sd2, 16'd682);
    send_segment(-32'sd5, 32'sd7, 32'sd1, -32'sd1, 16'd513);
    send_segment(hi, hi, hi, hi, 16'd1023);
    send_segment(lo, lo, lo, lo, 16'd0);
    send_random_segment(16'd1024);
    send_random_segment(16'hFFFF);
    send_random_segment(16'h8000);
    for (int i = 0; i < 8; i++) send_random_segment(IDX_W'($urandom_range(1023)));
  endtask

  // Sweep depth through its extremes, including values that saturate.
  task automatic test_depth_settings();
    logic [DEPTH_W-1:0] depths[10];
    int                 span;
    depths = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd15, 4'd9, 4'd4, 4'd7, 4'd3, 4'd6};
    foreach (depths[k]) begin
      set_depth(depths[k]);
      // a write past the register list must leave depth alone
      if (k == 4) write_register(ADDR_UNUSED, 32'h0000_0001);
      span = 1 << (2 * active_levels());
      send_random_segment('0);
      send_random_segment(IDX_W'(span - 1));
      if (span <= 65535) send_random_segment(IDX_W'(span));
      send_random_segment(16'hFFFF);
      repeat (2) send_random_segment(pick_index());
    end
  endtask

  task automatic test_random_traffic();
    int                 idle_pcts[4];
    int                 stall_pcts[4];
    logic [DEPTH_W-1:0] phase_depths[4];
    idle_pcts    = '{0, 60, 0, 29};
    stall_pcts   = '{0, 0, 60, 29};
    phase_depths = '{4'd8, DEPTH_W'($urandom_range(15)), 4'd5, 4'd15};
    for (int p = 0; p < 4; p++) begin
      set_depth(phase_depths[p]);
      send_idle_pct = idle_pcts[p];
      stall_pct     = stall_pcts[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // pause mid-stream until the pipeline is empty
        if (i == PHASE_ITEMS / 2 && p == 1) wait_drained();
        send_random_segment(pick_index());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_depth_settings();
    test_random_traffic();

    wait_drained();
    stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
